### rtl/fcv_pkg.sv
package fcv_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEF = 1023;
  localparam int unsigned MIN_FRAME_LEN     = 5;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_CRC_FAIL = 2'd2
  } status_e;

  typedef struct packed {
    logic        frame_ok;
    status_e     status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } result_t;

  // One byte through the CRC-16/XModem register, MSB first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/fcv_if.sv
interface fcv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcv_res_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [1:0]  status;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;

  modport source (output valid, output frame_ok, output status, output computed_crc,
                  output received_crc, input ready);
  modport sink   (input valid, input frame_ok, input status, input computed_crc,
                  input received_crc, output ready);
endinterface

### rtl/frame_crc16_validator.sv
// Channel   Dir  Word                                       Handshake
// byte_i    in   data_byte[7:0], last_byte                  valid/ready
// result_o  out  frame_ok, status[1:0], computed_crc[15:0], valid/ready
//                received_crc[15:0]
//
// One byte is accepted per unstalled cycle, a rate the unrolled 8-bit CRC update sets.
// A frame's result is registered in the output buffer as its final byte is accepted.
// Reset (rst_ni low) clears the CRC, the tail bytes, the count and both result slots.
// While the output is stalled, a second result is held in a skid slot; input
// stalls only while that slot is occupied.
module frame_crc16_validator #(
  parameter int unsigned MAX_FRAME_LEN = fcv_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcv_byte_if.sink   byte_i,
  fcv_res_if.source  result_o
);

  // The byte counter only needs to reach the saturation value.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);

  logic [15:0]      crc_q;
  logic [7:0]       tail_q [3];
  logic [CNT_W-1:0] cnt_q;

  logic             accept;
  logic             buf_full;
  logic [15:0]      crc_next;
  logic [15:0]      rx_crc;
  logic             short_frame;
  logic             crc_match;
  fcv_pkg::result_t result;

  assign byte_i.ready = ~buf_full;
  assign accept       = byte_i.valid & byte_i.ready;

  // The oldest held byte enters the CRC once three bytes are waiting in the tail.
  assign crc_next = (cnt_q >= CNT_W'(3)) ? fcv_pkg::crc_feed(crc_q, tail_q[2]) : crc_q;

  // On the final byte, the two bytes before it carry the CRC, high byte first.
  assign rx_crc      = {tail_q[1], tail_q[0]};
  assign short_frame = cnt_q < CNT_W'(fcv_pkg::MIN_FRAME_LEN - 1);
  assign crc_match   = rx_crc == crc_next;

  always_comb begin
    if (short_frame) begin
      result.frame_ok     = 1'b0;
      result.status       = fcv_pkg::STATUS_SHORT;
      result.computed_crc = 16'h0000;
      result.received_crc = 16'h0000;
    end else begin
      result.frame_ok     = crc_match;
      result.status       = crc_match ? fcv_pkg::STATUS_VALID : fcv_pkg::STATUS_CRC_FAIL;
      result.computed_crc = crc_next;
      result.received_crc = rx_crc;
    end
  end

  // Frame state: a final byte returns everything to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= fcv_pkg::CRC_INIT;
      tail_q[0] <= 8'h00;
      tail_q[1] <= 8'h00;
      tail_q[2] <= 8'h00;
      cnt_q     <= '0;
    end else if (accept) begin
      if (byte_i.last_byte) begin
        crc_q     <= fcv_pkg::CRC_INIT;
        tail_q[0] <= 8'h00;
        tail_q[1] <= 8'h00;
        tail_q[2] <= 8'h00;
        cnt_q     <= '0;
      end else begin
        crc_q     <= crc_next;
        tail_q[0] <= byte_i.data_byte;
        tail_q[1] <= tail_q[0];
        tail_q[2] <= tail_q[1];
        if (cnt_q < CNT_W'(MAX_FRAME_LEN)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  fcv_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & byte_i.last_byte),
    .push_data_i (result),
    .full_o      (buf_full),
    .res_o       (result_o)
  );

endmodule

### rtl/fcv_out_buf.sv
// Two-entry result buffer: an output register and a skid register behind it.
module fcv_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcv_pkg::result_t push_data_i,
  output logic             full_o,
  fcv_res_if.source        res_o
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  fcv_pkg::result_t out_q, out_d;
  fcv_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop = out_vld_q & res_o.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = push_i;
        skid_d     = push_data_i;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q) begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o             = skid_vld_q;
  assign res_o.valid        = out_vld_q;
  assign res_o.frame_ok     = out_q.frame_ok;
  assign res_o.status       = out_q.status;
  assign res_o.computed_crc = out_q.computed_crc;
  assign res_o.received_crc = out_q.received_crc;

endmodule

### rtl/fcv_checker.sv
module fcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        frame_ok_i,
  input logic [1:0]  status_i,
  input logic [15:0] computed_crc_i,
  input logic [15:0] received_crc_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A fresh result follows an accepted final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("result without a final byte");

  // The pass flag and the status code agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_ok_i == (status_i == fcv_pkg::STATUS_VALID)))
    else $error("frame_ok and status disagree");

  // A pass means the two CRC values match, a mismatch means they differ.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != fcv_pkg::STATUS_SHORT |->
      (frame_ok_i == (computed_crc_i == received_crc_i)))
    else $error("CRC verdict inconsistent with CRC fields");

  // A short frame reports both CRC fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == fcv_pkg::STATUS_SHORT |->
      (computed_crc_i == 16'h0000 && received_crc_i == 16'h0000))
    else $error("short frame carries CRC values");

endmodule

bind frame_crc16_validator fcv_checker u_fcv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (byte_i.valid),
  .in_ready_i     (byte_i.ready),
  .in_last_i      (byte_i.last_byte),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .frame_ok_i     (result_o.frame_ok),
  .status_i       (result_o.status),
  .computed_crc_i (result_o.computed_crc),
  .received_crc_i (result_o.received_crc)
);

### sim/tb.sv
// Testbench for frame_crc16_validator.
//
// Frames are sent as a stream of byte words over the byte channel, with the
// last_byte flag set on the final word of each frame. Every accepted byte word
// goes through a local model of the CRC-16/XModem frame checker. When a word
// closes a frame, the model gives the result word that the block must send, and
// that result, or a directed row's typed result, is queued. The result monitor
// pops the oldest queued result per accepted word and compares it field by field.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;

  fcv_byte_if byte_ch ();
  fcv_res_if  res_ch ();

  frame_crc16_validator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_ch),
    .result_o(res_ch)
  );

  // 12 ns clock period.
  always #6 clk_i = ~clk_i;

  // One row of the directed table. Where "typed" is set on a final byte, the
  // result given in the row is expected instead of the model's result.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    fcv_pkg::result_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Results still owed by the block, oldest first.
  fcv_pkg::result_t frame_results_due[$];

  // Local copy of the checker state: running CRC, the three held bytes
  // (held_bytes[0] is the newest) and the saturating count of bytes received
  // before the current one.
  logic [15:0] crc_run;
  logic [7:0]  held_bytes[3];
  int unsigned rx_count;

  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned mismatches;

  // Flags that shape the idling of both sides.
  bit quiet_src;
  bit quiet_sink;
  bit squeeze_req;
  bit squeeze_done;

  fcv_pkg::result_t got_res;
  fcv_pkg::result_t head_due;

  // One byte into the CRC-16/XModem register, one bit at a time, MSB first.
  // The feedback bit is the register's top bit XOR the incoming data bit.
  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ fcv_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    crc_run       = fcv_pkg::CRC_INIT;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_bytes[2] = 8'h00;
    rx_count      = 0;
  endfunction

  // Advances the model by one accepted byte word. Returns 1 and fills res
  // when the word closes a frame.
  function automatic bit frame_check_byte(input logic [7:0] d, input logic l,
                                          output fcv_pkg::result_t res);
    int unsigned len;
    logic [15:0] rx_crc;
    res = '0;
    // The oldest held byte leaves the delay line and enters the CRC once
    // three bytes are waiting.
    if (rx_count >= 3) begin
      crc_run = crc_xmodem_byte(crc_run, held_bytes[2]);
    end
    if (!l) begin
      held_bytes[2] = held_bytes[1];
      held_bytes[1] = held_bytes[0];
      held_bytes[0] = d;
      if (rx_count < fcv_pkg::MAX_FRAME_LEN_DEF) begin
        rx_count++;
      end
      return 1'b0;
    end
    len = rx_count + 1;
    if (len > fcv_pkg::MAX_FRAME_LEN_DEF) begin
      len = fcv_pkg::MAX_FRAME_LEN_DEF;
    end
    // The CRC sits in the two bytes before the end marker, high byte first.
    rx_crc = {held_bytes[1], held_bytes[0]};
    if (len < fcv_pkg::MIN_FRAME_LEN) begin
      res = {1'b0, fcv_pkg::STATUS_SHORT, 16'h0000, 16'h0000};
    end else begin
      res.frame_ok     = (rx_crc == crc_run);
      res.status       = (rx_crc == crc_run) ? fcv_pkg::STATUS_VALID
                                             : fcv_pkg::STATUS_CRC_FAIL;
      res.computed_crc = crc_run;
      res.received_crc = rx_crc;
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic add_row(input logic [7:0] d, input logic l, input logic typed,
                         input fcv_pkg::result_t want);
    directed_rows.push_back({d, l, typed, want});
  endtask

  // Offers one byte word after a random gap and waits for its handshake. The
  // accepted word is then run through the model. A typed result, when given,
  // replaces the model's result.
  task automatic send_word(input logic [7:0] d, input logic l, input logic typed,
                           input fcv_pkg::result_t want);
    int unsigned      gap;
    fcv_pkg::result_t res;
    gap = quiet_src ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.last_byte <= l;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
    if (frame_check_byte(d, l, res)) begin
      frame_results_due.push_back(typed ? want : res);
    end
  endtask

  // Sends a whole frame; the flag goes on its final byte. About a quarter of
  // the frames go out with no gaps at all.
  task automatic send_frame(input logic [7:0] frame[$]);
    quiet_src = ($urandom_range(0, 3) == 0);
    foreach (frame[i]) begin
      send_word(frame[i], (i == frame.size() - 1), 1'b0, '0);
    end
  endtask

  // Builds a frame with payload_len random payload bytes, the big-endian
  // CRC of the payload and a random end marker.
  task automatic build_good_frame(input int unsigned payload_len,
                                  output logic [7:0] frame[$]);
    logic [15:0] c;
    frame = {};
    c     = fcv_pkg::CRC_INIT;
    repeat (payload_len) begin
      frame.push_back(8'($urandom_range(0, 255)));
      c = crc_xmodem_byte(c, frame[$]);
    end
    frame.push_back(c[15:8]);
    frame.push_back(c[7:0]);
    frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // Reset: held low from the start, released at a rising edge.
  initial begin
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side. Before each result word the sink may hold ready low, except
  // during quiet stretches. Once the stimulus asks for it, the sink holds ready
  // low for a long stretch so that the result slots fill up and the block has
  // to stall its byte input.
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = quiet_sink ? 0 : $urandom_range(0, 3);
      if (squeeze_req && !squeeze_done) begin
        stall        = 120;
        squeeze_done = 1'b1;
      end
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      if (results_seen % 20 == 0) begin
        quiet_sink = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Result monitor. Values are read in the same step as the rising edge, so
  // they are the ones the block saw at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      got_res = {res_ch.frame_ok, fcv_pkg::status_e'(res_ch.status), res_ch.computed_crc,
                 res_ch.received_crc};
      if (frame_results_due.size() == 0) begin
        $display("%0t: result word with none expected: ok=%0d status=%0d comp=%h rx=%h",
                 $time, got_res.frame_ok, got_res.status, got_res.computed_crc,
                 got_res.received_crc);
        mismatches++;
      end else begin
        head_due = frame_results_due.pop_front();
        if (got_res.frame_ok !== head_due.frame_ok) begin
          $display("%0t: frame_ok expected %0d, got %0d", $time, head_due.frame_ok,
                   got_res.frame_ok);
          mismatches++;
        end
        if (got_res.status !== head_due.status) begin
          $display("%0t: status expected %0d, got %0d", $time, head_due.status,
                   got_res.status);
          mismatches++;
        end
        if (got_res.computed_crc !== head_due.computed_crc) begin
          $display("%0t: computed_crc expected %h, got %h", $time,
                   head_due.computed_crc, got_res.computed_crc);
          mismatches++;
        end
        if (got_res.received_crc !== head_due.received_crc) begin
          $display("%0t: received_crc expected %h, got %h", $time,
                   head_due.received_crc, got_res.received_crc);
          mismatches++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [7:0]  frame[$];
    int unsigned pick;
    int unsigned flip_at;
    bit          long_done;

    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    clear_frame_state();
    bytes_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    quiet_src    = 1'b0;
    quiet_sink   = 1'b0;
    squeeze_req  = 1'b0;
    squeeze_done = 1'b0;
    long_done    = 1'b0;

    // Directed table.
    // A one-byte frame straight after reset is too short.
    add_row(8'hFF, 1'b1, 1'b1, {1'b0, fcv_pkg::STATUS_SHORT, 16'h0000, 16'h0000});
    // A three-byte frame is too short as well; the CRC fields read as zero.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b1, 1'b1, {1'b0, fcv_pkg::STATUS_SHORT, 16'h0000, 16'h0000});
    // Shortest valid frame: the CRC of two zero bytes is zero.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b1, 1'b1, {1'b1, fcv_pkg::STATUS_VALID, 16'h0000, 16'h0000});
    // The same frame with a wrong low CRC byte.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, {1'b0, fcv_pkg::STATUS_CRC_FAIL, 16'h0000, 16'h0001});
    // The standard check string "123456789" has the XModem CRC 31C3.
    for (int i = 0; i < 9; i++) begin
      add_row(8'h31 + 8'(i), 1'b0, 1'b0, '0);
    end
    add_row(8'h31, 1'b0, 1'b0, '0);
    add_row(8'hC3, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, {1'b1, fcv_pkg::STATUS_VALID, 16'h31C3, 16'h31C3});
    // Five bytes of all ones: checked against the model only.
    repeat (4) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);

    @(posedge clk_i iff rst_ni);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // The sender pauses here until every owed result has arrived.
    byte_ch.valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);

    // Back-to-back one-byte frames while the sink holds off: the block runs
    // out of result slots and must stall the byte input.
    squeeze_req = 1'b1;
    quiet_src   = 1'b1;
    repeat (12) begin
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    end

    // Random frames. Most carry a correct CRC; the rest are corrupted,
    // random or too short. One frame runs past the byte count's maximum.
    while (bytes_sent < 1750) begin
      if (!long_done && bytes_sent > 700) begin
        long_done = 1'b1;
        build_good_frame($urandom_range(1021, 1030), frame);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          build_good_frame(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                       : $urandom_range(2, 24), frame);
        end else if (pick < 75) begin
          // A single flipped bit anywhere before the end marker.
          build_good_frame($urandom_range(2, 24), frame);
          flip_at        = $urandom_range(0, frame.size() - 2);
          frame[flip_at] = frame[flip_at] ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick < 85) begin
          frame = {};
          repeat ($urandom_range(5, 30)) frame.push_back(8'($urandom_range(0, 255)));
        end else begin
          frame = {};
          repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_frame(frame);
    end
    byte_ch.valid <= 1'b0;

    // Drain, then keep watching so that any stray result word would still show.
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/fcv_pkg.sv
rtl/fcv_if.sv
rtl/fcv_out_buf.sv
rtl/frame_crc16_validator.sv
rtl/fcv_checker.sv
sim/tb.sv
